FILE: rtl/jse_pkg.sv
// shared constants and controller/datapath interface types for joint_setting_entropy
`default_nettype none
package jse_pkg;
	localparam int DEF_MAX_SAMPLES = 1024;
	localparam int DEF_GENOME_BITS = 32;
	localparam int SAMPLE_W = 32;
	localparam int ENT_W = 20;
	localparam int LOG_FRAC = 24;
	localparam int MANT_FRAC = 30;
	localparam int MANT_W = 32;
	localparam int PBITS = 5;
	localparam int LOG_W = PBITS + LOG_FRAC;

	typedef struct packed {
		logic load_row;
		logic drop;
		logic next_idx;
		logic wr_inc;
		logic wr_new;
		logic log_load_n;
		logic log_load_c;
		logic log_step;
		logic mul_whole;
		logic mul_part;
		logic add_part;
		logic div_init;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic tot_zero;
		logic idx_last;
		logic match;
		logic last;
		logic log_done;
		logic div_done;
	} stat_t;
endpackage
`default_nettype wire

FILE: rtl/jse_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module jse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/jse_ctrl.sv
// sequencer for row lookup, log evaluation, summation and final division
`default_nettype none
module jse_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire jse_pkg::stat_t stat,
	output jse_pkg::cmd_t      cmd
);
	import jse_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_CMP   = 4'd2;
	localparam logic [3:0] S_INC   = 4'd3;
	localparam logic [3:0] S_NEW   = 4'd4;
	localparam logic [3:0] S_CHK   = 4'd5;
	localparam logic [3:0] S_LOGN  = 4'd6;
	localparam logic [3:0] S_WHOLE = 4'd7;
	localparam logic [3:0] S_SRD   = 4'd8;
	localparam logic [3:0] S_SLD   = 4'd9;
	localparam logic [3:0] S_LOGC  = 4'd10;
	localparam logic [3:0] S_SMUL  = 4'd11;
	localparam logic [3:0] S_SADD  = 4'd12;
	localparam logic [3:0] S_DINIT = 4'd13;
	localparam logic [3:0] S_DIV   = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_row = 1'b1;
					if (stat.full) begin
						cmd.drop = 1'b1;
						state_d = S_CHK;
					end else if (stat.tot_zero) begin
						state_d = S_NEW;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				if (stat.match) begin
					state_d = S_INC;
				end else begin
					cmd.next_idx = 1'b1;
					state_d = stat.idx_last ? S_NEW : S_RD;
				end
			end
			S_INC: begin
				cmd.wr_inc = 1'b1;
				state_d = S_CHK;
			end
			S_NEW: begin
				cmd.wr_new = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.last) begin
					cmd.log_load_n = 1'b1;
					state_d = S_LOGN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LOGN: begin
				cmd.log_step = 1'b1;
				if (stat.log_done) begin
					state_d = S_WHOLE;
				end
			end
			S_WHOLE: begin
				cmd.mul_whole = 1'b1;
				state_d = S_SRD;
			end
			S_SRD: state_d = S_SLD;
			S_SLD: begin
				cmd.log_load_c = 1'b1;
				state_d = S_LOGC;
			end
			S_LOGC: begin
				cmd.log_step = 1'b1;
				if (stat.log_done) begin
					state_d = S_SMUL;
				end
			end
			S_SMUL: begin
				cmd.mul_part = 1'b1;
				state_d = S_SADD;
			end
			S_SADD: begin
				cmd.add_part = 1'b1;
				if (stat.idx_last) begin
					state_d = S_DINIT;
				end else begin
					cmd.next_idx = 1'b1;
					state_d = S_SRD;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/jse_dp.sv
// datapath: key/count tables, log2 unit, accumulator and restoring divider
`default_nettype none
module jse_dp #(
	parameter int MAX_SAMPLES = jse_pkg::DEF_MAX_SAMPLES,
	parameter int GENOME_BITS = jse_pkg::DEF_GENOME_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 var_mask_we,
	input  wire logic [jse_pkg::SAMPLE_W-1:0]         var_mask,
	input  wire logic [jse_pkg::SAMPLE_W-1:0]         sample_bits,
	input  wire logic                                 last_sample,
	input  wire jse_pkg::cmd_t                        cmd,
	output jse_pkg::stat_t                            stat,
	output logic                                      done,
	output logic [jse_pkg::ENT_W-1:0]                 entropy_q,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]          sample_count,
	output logic                                      overflow
);
	import jse_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int PW = CW + LOG_W;
	localparam int NW = PW + 1;
	localparam int DW = CW + 9;
	localparam int DCW = $clog2(NW);
	localparam int XW = GENOME_BITS + SAMPLE_W;

	logic [SAMPLE_W-1:0]    mask_q;
	logic [GENOME_BITS-1:0] key_q;
	logic                   last_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          total_q;
	logic [CW-1:0]          rows_q;
	logic                   drop_q;
	logic [GENOME_BITS-1:0] key_rd;
	logic [CW-1:0]          cnt_rd;
	logic [XW-1:0]          key_ext;

	// log2 unit state
	logic [MANT_W-1:0]      y_q;
	logic [LOG_FRAC-1:0]    frac_q;
	logic [PBITS-1:0]       p_q;
	logic [4:0]             lcnt_q;
	logic [CW-1:0]          log_x;
	logic [PBITS-1:0]       p_d;
	logic [2*MANT_W-1:0]    sq;
	logic [MANT_W-1:0]      yn;
	logic [LOG_W-1:0]       lval;

	logic [PW-1:0]          whole_q;
	logic [PW-1:0]          parts_q;
	logic [PW-1:0]          prod_q;
	logic [PW-1:0]          diff;
	logic [NW-1:0]          num_q;
	logic [DW-1:0]          rem_q;
	logic [DCW-1:0]         dcnt_q;
	logic [DW-1:0]          den;
	logic [DW-1:0]          trial;

	assign key_ext = XW'(sample_bits & mask_q);

	jse_ram #(.WIDTH(GENOME_BITS), .DEPTH(MAX_SAMPLES)) u_keys (
		.clk   (clk),
		.we    (cmd.wr_new),
		.waddr (idx_q[AW-1:0]),
		.wdata (key_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (key_rd)
	);

	jse_ram #(.WIDTH(CW), .DEPTH(MAX_SAMPLES)) u_cnts (
		.clk   (clk),
		.we    (cmd.wr_inc | cmd.wr_new),
		.waddr (idx_q[AW-1:0]),
		.wdata (cmd.wr_new ? CW'(1) : cnt_rd + CW'(1)),
		.raddr (idx_q[AW-1:0]),
		.rdata (cnt_rd)
	);

	assign stat.full     = (rows_q == CW'(MAX_SAMPLES));
	assign stat.tot_zero = (total_q == '0);
	assign stat.idx_last = ((idx_q + CW'(1)) == total_q);
	assign stat.match    = (key_rd == key_q);
	assign stat.last     = last_q;
	assign stat.log_done = (lcnt_q == 5'(LOG_FRAC - 1));
	assign stat.div_done = (dcnt_q == DCW'(NW - 1));

	// integer part of log2: index of the top set bit
	assign log_x = cmd.log_load_n ? rows_q : cnt_rd;
	always_comb begin
		p_d = '0;
		for (int i = 0; i < CW; i++) begin
			if (log_x[i]) begin
				p_d = PBITS'(i);
			end
		end
	end

	assign sq   = y_q * y_q;
	assign yn   = sq[MANT_FRAC+MANT_W-1:MANT_FRAC];
	assign lval = {p_q, frac_q};
	assign diff = (parts_q > whole_q) ? '0 : whole_q - parts_q;
	assign den  = DW'({rows_q, 8'b0});
	assign trial = {rem_q[DW-2:0], num_q[NW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load_row) begin
			key_q  <= key_ext[GENOME_BITS-1:0];
			last_q <= last_sample;
		end
		if (cmd.log_load_n || cmd.log_load_c) begin
			p_q    <= p_d;
			y_q    <= MANT_W'(log_x) << (5'(MANT_FRAC) - 5'(p_d));
			frac_q <= '0;
		end else if (cmd.log_step) begin
			if (yn[MANT_W-1]) begin
				y_q    <= yn >> 1;
				frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
			end else begin
				y_q    <= yn;
				frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
			end
		end
		if (cmd.mul_whole) begin
			whole_q <= PW'(rows_q) * PW'(lval);
			parts_q <= '0;
		end
		if (cmd.mul_part) begin
			prod_q <= PW'(cnt_rd) * PW'(lval);
		end
		if (cmd.add_part) begin
			parts_q <= parts_q + prod_q;
		end
		if (cmd.div_init) begin
			num_q <= {1'b0, diff} + NW'({rows_q, 7'b0});
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= den) begin
				rem_q <= trial - den;
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			entropy_q    <= (|num_q[NW-1:ENT_W]) ? '1 : num_q[ENT_W-1:0];
			sample_count <= rows_q;
			overflow     <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '1;
			idx_q   <= '0;
			total_q <= '0;
			rows_q  <= '0;
			drop_q  <= 1'b0;
			lcnt_q  <= '0;
			dcnt_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (var_mask_we) begin
				mask_q <= var_mask;
			end
			if (cmd.load_row || cmd.mul_whole) begin
				idx_q <= '0;
			end else if (cmd.next_idx) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.drop) begin
				drop_q <= 1'b1;
			end
			if (cmd.wr_new) begin
				total_q <= total_q + CW'(1);
			end
			if (cmd.wr_inc || cmd.wr_new) begin
				rows_q <= rows_q + CW'(1);
			end
			if (cmd.log_load_n || cmd.log_load_c) begin
				lcnt_q <= '0;
			end else if (cmd.log_step) begin
				lcnt_q <= lcnt_q + 5'd1;
			end
			if (cmd.div_init) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DCW'(1);
			end
			// a delivered result starts a fresh set
			if (cmd.emit) begin
				total_q <= '0;
				rows_q  <= '0;
				drop_q  <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/joint_setting_entropy.sv
// top level: joint entropy of masked sample rows, controller plus datapath
// a row scans the stored distinct keys linearly through the key ram read port
// a last row then runs log2 of the row count, a log2 and multiply-accumulate per distinct key, and the division
// result is registered in the output state after the final division step, strobed by done for one cycle
// the receiver cannot stall; reset clears the set, mask resets to all ones
// key and count rams need no clearing: entries are read only after they are written
`default_nettype none
module joint_setting_entropy #(
	parameter int MAX_SAMPLES = jse_pkg::DEF_MAX_SAMPLES,
	parameter int GENOME_BITS = jse_pkg::DEF_GENOME_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 var_mask_we,
	input  wire logic [jse_pkg::SAMPLE_W-1:0]         var_mask,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [jse_pkg::SAMPLE_W-1:0]         sample_bits,
	input  wire logic                                 last_sample,
	output logic                                      done,
	output logic [jse_pkg::ENT_W-1:0]                 entropy_q,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]          sample_count,
	output logic                                      overflow
);
	import jse_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	jse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	jse_dp #(.MAX_SAMPLES(MAX_SAMPLES), .GENOME_BITS(GENOME_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.var_mask_we  (var_mask_we),
		.var_mask     (var_mask),
		.sample_bits  (sample_bits),
		.last_sample  (last_sample),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.entropy_q    (entropy_q),
		.sample_count (sample_count),
		.overflow     (overflow)
	);
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// testbench for joint_setting_entropy: directed table plus random sample sets, predictor check
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import jse_pkg::*;

	localparam int CAP = DEF_MAX_SAMPLES;

	typedef struct {
		logic [ENT_W-1:0] ent;
		logic [10:0]      cnt;
		logic             ovf;
	} hist_result_t;

	typedef struct {
		logic [31:0]      bits;
		logic             last;
		logic             typed;
		logic [ENT_W-1:0] ent;
		logic [10:0]      cnt;
		logic             ovf;
	} row_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic var_mask_we = 1'b0;
	logic [31:0] var_mask = '0;
	logic start = 1'b0;
	logic [31:0] sample_bits = '0;
	logic last_sample = 1'b0;
	logic busy, done, overflow;
	logic [ENT_W-1:0] entropy_q;
	logic [10:0] sample_count;

	joint_setting_entropy dut (
		.clk(clk), .arst_n(arst_n), .var_mask_we(var_mask_we), .var_mask(var_mask),
		.start(start), .busy(busy), .sample_bits(sample_bits), .last_sample(last_sample),
		.done(done), .entropy_q(entropy_q), .sample_count(sample_count), .overflow(overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("timeout at %0t", $time);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// histogram model
	logic [31:0] hist_mask = 32'hFFFF_FFFF;
	logic [31:0] hist_keys [CAP];
	int unsigned hist_counts [CAP];
	int unsigned hist_distinct = 0;
	int unsigned hist_rows = 0;
	logic hist_dropped = 1'b0;

	hist_result_t pending_results[$];
	int errors = 0;
	int rows_sent = 0;
	int sets_done = 0;
	int overflow_sets = 0;
	int idle_pct = 20;

	function automatic logic [63:0] log2_q24(input int unsigned x);
		int unsigned p;
		logic [63:0] y, f;
		p = 0;
		f = '0;
		if (x == 0)
			return '0;
		while (p < 31 && (x >> (p + 1)) != 0)
			p++;
		y = ({32'b0, x} << MANT_FRAC) >> p;
		for (int i = 0; i < LOG_FRAC; i++) begin
			y = (y * y) >> MANT_FRAC;
			f = f << 1;
			if (y >= (64'd2 << MANT_FRAC)) begin
				f = f | 64'd1;
				y = y >> 1;
			end
		end
		return (64'(p) << LOG_FRAC) | f;
	endfunction

	// updates the histogram with one row; returns 1 when the row closes a set
	function automatic bit count_row(input logic [31:0] bits, input logic last,
			output hist_result_t res);
		logic [31:0] key;
		logic [63:0] whole, parts, d, q;
		int unsigned i;
		key = bits & hist_mask;
		if (hist_rows >= CAP) begin
			hist_dropped = 1'b1;
		end else begin
			for (i = 0; i < hist_distinct; i++)
				if (hist_keys[i] == key)
					break;
			if (i < hist_distinct) begin
				hist_counts[i]++;
			end else begin
				hist_keys[hist_distinct] = key;
				hist_counts[hist_distinct] = 1;
				hist_distinct++;
			end
			hist_rows++;
		end
		if (!last)
			return 0;
		whole = 64'(hist_rows) * log2_q24(hist_rows);
		parts = '0;
		for (i = 0; i < hist_distinct; i++)
			parts += 64'(hist_counts[i]) * log2_q24(hist_counts[i]);
		d = (parts > whole) ? 64'd0 : whole - parts;
		q = (hist_rows == 0) ? 64'd0 :
			(d + (64'(hist_rows) << 7)) / (64'(hist_rows) << 8);
		if (q > 64'hFFFFF)
			q = 64'hFFFFF;
		res.ent = q[ENT_W-1:0];
		res.cnt = hist_rows[10:0];
		res.ovf = hist_dropped;
		hist_distinct = 0;
		hist_rows = 0;
		hist_dropped = 1'b0;
		return 1;
	endfunction

	// sends one row and records what it should produce
	task automatic send_row(input logic [31:0] bits, input logic last, input logic typed,
			input hist_result_t typed_res);
		hist_result_t res;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		sample_bits <= bits;
		last_sample <= last;
		do @(posedge clk); while (busy);
		rows_sent++;
		if (count_row(bits, last, res)) begin
			pending_results.push_back(typed ? typed_res : res);
			sets_done++;
			if (res.ovf)
				overflow_sets++;
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mask(input logic [31:0] m);
		wait_idle();
		var_mask_we <= 1'b1;
		var_mask <= m;
		@(posedge clk);
		var_mask_we <= 1'b0;
		hist_mask = m;
	endtask

	// result beats cannot be held off, take each one at the edge that ends it
	always @(posedge clk) begin
		hist_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat ent=%0d cnt=%0d ovf=%0b", $time,
					entropy_q, sample_count, overflow);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (entropy_q !== e.ent) begin
					$display("%0t: entropy_q exp %0d got %0d", $time, e.ent, entropy_q);
					errors++;
				end
				if (sample_count !== e.cnt) begin
					$display("%0t: sample_count exp %0d got %0d", $time, e.cnt, sample_count);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$display("%0t: overflow exp %0b got %0b", $time, e.ovf, overflow);
					errors++;
				end
			end
		end
	end

	row_vec_t directed_rows[14] = '{
		'{32'h0000_0000, 1'b1, 1'b1, 20'd0, 11'd1, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 20'd0, 11'd1, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 20'd0, 11'd0, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 20'd65536, 11'd2, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 20'd0, 11'd0, 1'b0},
		'{32'h8000_0000, 1'b0, 1'b0, 20'd0, 11'd0, 1'b0},
		'{32'h5555_5555, 1'b0, 1'b0, 20'd0, 11'd0, 1'b0},
		'{32'hAAAA_AAAA, 1'b1, 1'b1, 20'd131072, 11'd4, 1'b0},
		'{32'h1234_5678, 1'b0, 1'b0, 20'd0, 11'd0, 1'b0},
		'{32'h1234_5678, 1'b0, 1'b0, 20'd0, 11'd0, 1'b0},
		'{32'h1234_5678, 1'b1, 1'b1, 20'd0, 11'd3, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 20'd0, 11'd0, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 20'd0, 11'd0, 1'b0},
		'{32'h0000_0002, 1'b1, 1'b0, 20'd0, 11'd0, 1'b0}
	};

	initial begin
		hist_result_t r, none;
		logic [31:0] pool [8];
		logic [31:0] masks [5];
		int set_len;
		none = '{default: '0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i]) begin
			r.ent = directed_rows[i].ent;
			r.cnt = directed_rows[i].cnt;
			r.ovf = directed_rows[i].ovf;
			send_row(directed_rows[i].bits, directed_rows[i].last, directed_rows[i].typed, r);
		end

		// mask changed inside a set: stored keys keep their old projection
		write_mask(32'h0000_00FF);
		send_row(32'hFFFF_FF01, 1'b0, 1'b0, none);
		write_mask(32'h0000_0000);
		send_row(32'hFFFF_FF01, 1'b0, 1'b0, none);
		send_row(32'h0000_0000, 1'b1, 1'b0, none);

		// store full: mask 0 keeps every row on one key, so rows stay cheap
		for (int i = 0; i < CAP + 5; i++) begin
			r = '{ent: '0, cnt: 11'(CAP), ovf: 1'b1};
			send_row($urandom(), i == CAP + 4, i == CAP + 4, r);
		end
		write_mask(32'hFFFF_FFFF);

		masks = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_000F, 32'h8000_0001, 32'h0};
		while (rows_sent < 1200) begin
			masks[4] = $urandom();
			idle_pct = (rows_sent >= 1080 && rows_sent < 1140) ? 0 : 20;
			if ($urandom_range(3) == 0)
				write_mask(masks[$urandom_range(4)]);
			if (sets_done == 12)
				wait_idle();
			foreach (pool[k])
				pool[k] = $urandom();
			set_len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
			for (int j = 0; j < set_len; j++) begin
				if (j == set_len / 2 && $urandom_range(7) == 0)
					write_mask(masks[$urandom_range(4)]);
				send_row(($urandom_range(4) == 0) ? $urandom() : pool[$urandom_range(7)],
					j == set_len - 1, 1'b0, none);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		for (int t = 0; t < 200000 && (pending_results.size() != 0 || busy); t++)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("ran %0d rows in %0d sample sets, %0d of them past capacity, mask changes",
			rows_sent, sets_done, overflow_sets);
		$display("included mid-set; %0d errors", errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
rtl/jse_pkg.sv
rtl/jse_ram.sv
rtl/jse_ctrl.sv
rtl/jse_dp.sv
rtl/joint_setting_entropy.sv
verif/tb_top.sv
